[rtl/core/sample_rate_estimator_core_defines.svh]
// Assertion macros for the sample rate estimator core.
// Included by the checker; no other dependencies.
`ifndef SAMPLE_RATE_ESTIMATOR_CORE_DEFINES_SVH
`define SAMPLE_RATE_ESTIMATOR_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sre check failed (same cycle)");

// Consequent must hold in the cycle after the antecedent.
`define SRE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sre check failed (next cycle)");

`endif

[rtl/core/sre_pkg.sv]
// Shared types, constants and the microcode program of the sample rate estimator.
// No dependencies.
package sre_pkg;

	localparam int FRAC_BITS_DEFAULT = 5;

	localparam int CNT_W     = 16;
	localparam int TS_W      = 32;
	localparam int RATE_W    = 20;
	localparam int OUT_W     = 26;
	localparam int SAMP_W    = 40;
	localparam int TIME_W    = 34;
	localparam int MUL_IN_W  = SAMP_W / 2;
	localparam int CFG_IDX_W = 2;
	localparam int PC_W      = 4;

	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_RATE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_RATE = CFG_IDX_W'(1);

	localparam logic [RATE_W-1:0]   RATE_RESET  = RATE_W'(48000);
	localparam logic [MUL_IN_W-1:0] MICRO       = MUL_IN_W'(1000000);
	localparam logic [TIME_W-1:0]   TIME_INIT   = TIME_W'(384000000);
	localparam logic [TIME_W-1:0]   TIME_SHRINK = TIME_W'(512000000);

	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t PC_IDLE     = PC_W'(0);
	localparam pc_t PC_CHECK    = PC_W'(1);
	localparam pc_t PC_ACCUM    = PC_W'(2);
	localparam pc_t PC_MUL_LO   = PC_W'(3);
	localparam pc_t PC_MUL_HI   = PC_W'(4);
	localparam pc_t PC_NUM_ADD  = PC_W'(5);
	localparam pc_t PC_NUM_FIN  = PC_W'(6);
	localparam pc_t PC_DIV      = PC_W'(7);
	localparam pc_t PC_BLEND    = PC_W'(8);
	localparam pc_t PC_DEV      = PC_W'(9);
	localparam pc_t PC_SHRINK   = PC_W'(10);
	localparam pc_t PC_WAIT     = PC_W'(11);
	localparam pc_t PC_RESULT   = PC_W'(12);
	localparam pc_t PC_LOAD     = PC_W'(13);
	localparam pc_t PC_LOAD_ACC = PC_W'(14);

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD_EST,
		OP_LOAD_ACC,
		OP_ACCUM,
		OP_MUL_LO,
		OP_MUL_HI,
		OP_NUM_ADD,
		OP_NUM_FIN,
		OP_DIV,
		OP_BLEND,
		OP_DEV,
		OP_SHRINK,
		OP_RESULT
	} sre_op_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_NO_LAST,
		C_DIV_MORE,
		C_OUT_BUSY,
		C_NO_ITEM
	} sre_cond_t;

	typedef struct packed {
		sre_op_t   op;
		sre_cond_t cond;
		pc_t       target;
	} sre_uword_t;

	typedef struct packed {
		sre_op_t op;
		logic    idle;
	} sre_ctrl_t;

	typedef struct packed {
		logic have_last;
		logic div_more;
		logic out_busy;
	} sre_status_t;

	// Microcode program: execute op, then jump to target when cond holds.
	function automatic sre_uword_t sre_rom(input pc_t pc);
		sre_uword_t w;
		unique case (pc)
			PC_IDLE:     w = '{OP_NOP,      C_NO_ITEM,  PC_IDLE};
			PC_CHECK:    w = '{OP_NOP,      C_NO_LAST,  PC_WAIT};
			PC_ACCUM:    w = '{OP_ACCUM,    C_NEXT,     PC_IDLE};
			PC_MUL_LO:   w = '{OP_MUL_LO,   C_NEXT,     PC_IDLE};
			PC_MUL_HI:   w = '{OP_MUL_HI,   C_NEXT,     PC_IDLE};
			PC_NUM_ADD:  w = '{OP_NUM_ADD,  C_NEXT,     PC_IDLE};
			PC_NUM_FIN:  w = '{OP_NUM_FIN,  C_NEXT,     PC_IDLE};
			PC_DIV:      w = '{OP_DIV,      C_DIV_MORE, PC_DIV};
			PC_BLEND:    w = '{OP_BLEND,    C_NEXT,     PC_IDLE};
			PC_DEV:      w = '{OP_DEV,      C_NEXT,     PC_IDLE};
			PC_SHRINK:   w = '{OP_SHRINK,   C_NEXT,     PC_IDLE};
			PC_WAIT:     w = '{OP_NOP,      C_OUT_BUSY, PC_WAIT};
			PC_RESULT:   w = '{OP_RESULT,   C_ALWAYS,   PC_IDLE};
			PC_LOAD:     w = '{OP_LOAD_EST, C_NEXT,     PC_IDLE};
			PC_LOAD_ACC: w = '{OP_LOAD_ACC, C_ALWAYS,   PC_IDLE};
			default:     w = '{OP_NOP,      C_ALWAYS,   PC_IDLE};
		endcase
		return w;
	endfunction

endpackage

[rtl/core/sre_sequencer.sv]
// Microcode sequencer: step counter, program table lookup and conditional jumps.
// Depends on sre_pkg.
module sre_sequencer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_accept,
	input  logic                  cfg_we,
	input  sre_pkg::sre_status_t  status,
	output sre_pkg::sre_ctrl_t    ctrl
);

	sre_pkg::pc_t       pc_q;
	sre_pkg::pc_t       pc_next;
	sre_pkg::sre_uword_t uword;
	logic               take;

	assign uword = sre_pkg::sre_rom(pc_q);

	always_comb begin
		unique case (uword.cond)
			sre_pkg::C_NEXT:     take = 1'b0;
			sre_pkg::C_ALWAYS:   take = 1'b1;
			sre_pkg::C_NO_LAST:  take = !status.have_last;
			sre_pkg::C_DIV_MORE: take = status.div_more;
			sre_pkg::C_OUT_BUSY: take = status.out_busy;
			sre_pkg::C_NO_ITEM:  take = !item_accept;
			default:             take = 1'b1;
		endcase
	end

	always_comb begin
		// a register write reloads the state from the new settings
		priority if (pc_q == sre_pkg::PC_IDLE && cfg_we) begin
			pc_next = sre_pkg::PC_LOAD;
		end else if (take) begin
			pc_next = uword.target;
		end else begin
			pc_next = pc_q + sre_pkg::PC_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= sre_pkg::PC_LOAD;
		end else begin
			pc_q <= pc_next;
		end
	end

	assign ctrl.op   = uword.op;
	assign ctrl.idle = (pc_q == sre_pkg::PC_IDLE);

endmodule

[rtl/core/sre_datapath.sv]
// Datapath: settings, estimator state, constant multiplier, restoring divider
// and the output register. Driven one micro-op per cycle. Depends on sre_pkg.
module sre_datapath #(
	parameter int FRAC_BITS = sre_pkg::FRAC_BITS_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sre_pkg::sre_ctrl_t               ctrl,
	output sre_pkg::sre_status_t             status,
	input  logic                             item_accept,
	input  logic [sre_pkg::CNT_W-1:0]        sample_count,
	input  logic [sre_pkg::TS_W-1:0]         timestamp_us,
	input  logic                             cfg_we,
	input  logic [sre_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sre_pkg::RATE_W-1:0]       cfg_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [sre_pkg::OUT_W-1:0]        rate_estimate,
	output logic [sre_pkg::OUT_W-1:0]        rate_deviation
);

	localparam int RATE_W  = sre_pkg::RATE_W;
	localparam int OUT_W   = sre_pkg::OUT_W;
	localparam int SAMP_W  = sre_pkg::SAMP_W;
	localparam int TIME_W  = sre_pkg::TIME_W;
	localparam int TS_W    = sre_pkg::TS_W;
	localparam int CNT_W   = sre_pkg::CNT_W;
	localparam int MIN_W   = sre_pkg::MUL_IN_W;
	localparam int MUL_W   = 2 * MIN_W;
	localparam int RW      = RATE_W + FRAC_BITS;
	localparam int EW      = RW + 1;
	localparam int DW      = EW + 5;
	localparam int INST_W  = SAMP_W + 1;
	localparam int BW      = (EW + 6 > INST_W + 1) ? EW + 6 : INST_W + 1;
	localparam int NW      = SAMP_W + MIN_W + FRAC_BITS + 2;
	localparam int STEP_W  = $clog2(NW);
	localparam int REM_W   = TIME_W + 1;
	localparam int SSUM_W  = SAMP_W + 1;
	localparam int TSUM_W  = TS_W + 6;
	localparam int SHR_W   = SAMP_W + 2;

	// settings
	logic [RATE_W-1:0] init_rate_q;
	logic [RATE_W-1:0] ref_rate_q;

	// estimator state
	logic [EW-1:0]     est_q;
	logic [EW-1:0]     dev_q;
	logic [SAMP_W-1:0] samp_q;
	logic [TIME_W-1:0] time_q;
	logic [TS_W-1:0]   last_ts_q;
	logic              have_last_q;

	// item and work registers
	logic [CNT_W-1:0]  cnt_q;
	logic [TS_W-1:0]   ts_q;
	logic [MUL_W-1:0]  mul_q;
	logic [NW-1:0]     num_q;
	logic [REM_W-1:0]  dvs_q;
	logic [REM_W-1:0]  rem_q;
	logic [SAMP_W-1:0] quo_q;
	logic              big_q;
	logic [STEP_W-1:0] step_q;
	logic [EW-1:0]     nxt_q;

	// result register
	logic              out_valid_q;
	logic [OUT_W-1:0]  est_out_q;
	logic [OUT_W-1:0]  dev_out_q;

	logic [RW-1:0]     ref_sc;
	logic [RW-1:0]     init_sc;
	logic [RW-1:0]     lim;
	logic [EW-1:0]     hi_bound;
	logic [EW-1:0]     lo_bound;
	logic [EW-1:0]     est_load;
	logic [SAMP_W-1:0] est_int;
	logic [SAMP_W-1:0] samp_load;
	logic [SSUM_W-1:0] samp_sum;
	logic [SAMP_W-1:0] samp_acc;
	logic [TS_W-1:0]   dt;
	logic [TSUM_W-1:0] time_sum;
	logic [TIME_W-1:0] time_acc;
	logic [MIN_W-1:0]  mul_a;
	logic [MUL_W-1:0]  mul_p;
	logic [REM_W:0]    rem_sh;
	logic              qbit;
	logic [REM_W:0]    rem_sub;
	logic [SAMP_W:0]   quo_sh;
	logic [INST_W-1:0] inst;
	logic [BW-1:0]     blend_sum;
	logic [BW-1:0]     blend_sh;
	logic [EW-1:0]     blend_clamp;
	logic [EW-1:0]     diff;
	logic [DW-1:0]     dev_sum;
	logic [SHR_W-1:0]  samp_shr;
	logic [SHR_W-1:0]  time_shr;
	logic              out_take;

	// clamp window: reference plus or minus one sixty-fourth
	assign ref_sc   = RW'(ref_rate_q) << FRAC_BITS;
	assign init_sc  = RW'(init_rate_q) << FRAC_BITS;
	assign lim      = ref_sc >> 6;
	assign hi_bound = EW'(ref_sc) + EW'(lim);
	assign lo_bound = EW'(ref_sc) - EW'(lim);

	always_comb begin
		priority if (EW'(init_sc) > hi_bound) begin
			est_load = hi_bound;
		end else if (EW'(init_sc) < lo_bound) begin
			est_load = lo_bound;
		end else begin
			est_load = EW'(init_sc);
		end
	end

	// sample accumulator start: integer estimate times 12 times 32
	assign est_int   = SAMP_W'(est_q >> FRAC_BITS);
	assign samp_load = (est_int << 8) + (est_int << 7);

	// saturating accumulation
	assign samp_sum = SSUM_W'(samp_q) + (SSUM_W'(cnt_q) << 5);
	assign samp_acc = samp_sum[SAMP_W] ? {SAMP_W{1'b1}} : samp_sum[SAMP_W-1:0];
	assign dt       = ts_q - last_ts_q;
	assign time_sum = TSUM_W'(time_q) + (TSUM_W'(dt) << 5);
	assign time_acc = (time_sum > TSUM_W'({TIME_W{1'b1}})) ? {TIME_W{1'b1}}
	                                                        : time_sum[TIME_W-1:0];

	// one 20x20 product per cycle against the microsecond scale
	assign mul_a = (ctrl.op == sre_pkg::OP_MUL_HI) ? samp_q[SAMP_W-1:MIN_W]
	                                               : samp_q[MIN_W-1:0];
	assign mul_p = MUL_W'(mul_a) * MUL_W'(sre_pkg::MICRO);

	// restoring division, one quotient bit per cycle
	assign rem_sh  = {rem_q, num_q[NW-1]};
	assign qbit    = (rem_sh >= {1'b0, dvs_q});
	assign rem_sub = qbit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
	assign quo_sh  = {quo_q, qbit};

	// a quotient that reached 2^40 saturates there
	assign inst = big_q ? {1'b1, {SAMP_W{1'b0}}} : {1'b0, quo_q};

	assign blend_sum = (BW'(est_q) << 5) - BW'(est_q) + BW'(inst) + BW'(16);
	assign blend_sh  = blend_sum >> 5;

	always_comb begin
		priority if (blend_sh > BW'(hi_bound)) begin
			blend_clamp = hi_bound;
		end else if (blend_sh < BW'(lo_bound)) begin
			blend_clamp = lo_bound;
		end else begin
			blend_clamp = EW'(blend_sh);
		end
	end

	assign diff    = (nxt_q >= est_q) ? (nxt_q - est_q) : (est_q - nxt_q);
	assign dev_sum = (DW'(dev_q) << 4) - DW'(dev_q) + DW'(diff) + DW'(8);

	assign samp_shr = ((SHR_W'(samp_q) << 1) + SHR_W'(samp_q) + SHR_W'(2)) >> 2;
	assign time_shr = ((SHR_W'(time_q) << 1) + SHR_W'(time_q) + SHR_W'(2)) >> 2;

	assign out_take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_rate_q <= sre_pkg::RATE_RESET;
			ref_rate_q  <= sre_pkg::RATE_RESET;
			have_last_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == sre_pkg::REG_INITIAL_RATE) begin
					init_rate_q <= cfg_data;
				end else if (cfg_index == sre_pkg::REG_REFERENCE_RATE) begin
					ref_rate_q <= cfg_data;
				end
			end
			if (out_take) begin
				out_valid_q <= 1'b0;
			end
			unique case (ctrl.op)
				sre_pkg::OP_LOAD_EST: have_last_q <= 1'b0;
				sre_pkg::OP_RESULT: begin
					have_last_q <= 1'b1;
					out_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			cnt_q <= sample_count;
			ts_q  <= timestamp_us;
		end
		unique case (ctrl.op)
			sre_pkg::OP_LOAD_EST: begin
				est_q  <= est_load;
				dev_q  <= EW'(init_sc >> 12);
				time_q <= sre_pkg::TIME_INIT;
			end
			sre_pkg::OP_LOAD_ACC: samp_q <= samp_load;
			sre_pkg::OP_ACCUM: begin
				samp_q <= samp_acc;
				time_q <= time_acc;
			end
			sre_pkg::OP_MUL_LO: mul_q <= mul_p;
			sre_pkg::OP_MUL_HI: begin
				num_q <= NW'(mul_q);
				mul_q <= mul_p;
			end
			sre_pkg::OP_NUM_ADD: num_q <= num_q + (NW'(mul_q) << MIN_W);
			sre_pkg::OP_NUM_FIN: begin
				num_q  <= (num_q << (FRAC_BITS + 1)) + NW'(time_q);
				dvs_q  <= {time_q, 1'b0};
				rem_q  <= '0;
				quo_q  <= '0;
				big_q  <= 1'b0;
				step_q <= STEP_W'(NW - 1);
			end
			sre_pkg::OP_DIV: begin
				rem_q  <= rem_sub[REM_W-1:0];
				quo_q  <= quo_sh[SAMP_W-1:0];
				big_q  <= big_q | quo_sh[SAMP_W];
				num_q  <= num_q << 1;
				step_q <= step_q - STEP_W'(1);
			end
			sre_pkg::OP_BLEND: nxt_q <= blend_clamp;
			sre_pkg::OP_DEV: begin
				dev_q <= EW'(dev_sum >> 4);
				est_q <= nxt_q;
			end
			sre_pkg::OP_SHRINK: begin
				if (time_q > sre_pkg::TIME_SHRINK) begin
					samp_q <= SAMP_W'(samp_shr);
					time_q <= TIME_W'(time_shr);
				end
			end
			sre_pkg::OP_RESULT: begin
				last_ts_q <= ts_q;
				est_out_q <= OUT_W'(est_q);
				dev_out_q <= OUT_W'(dev_q);
			end
			default: ;
		endcase
	end

	assign status.have_last = have_last_q;
	assign status.div_more  = (step_q != '0);
	assign status.out_busy  = out_valid_q && out_stall;

	assign out_valid      = out_valid_q;
	assign rate_estimate  = est_out_q;
	assign rate_deviation = dev_out_q;

endmodule

[rtl/core/sample_rate_estimator_core.sv]
// Channel | direction | handshake            | payload
// in      | receive   | in_valid / in_stall   | sample_count, timestamp_us
// out     | send      | out_valid / out_stall | rate_estimate, rate_deviation
// cfg     | receive   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// After a report is accepted the next one is held off until its update is
// finished; the first report after a reload only records its timestamp.
// The restoring divider works one quotient bit per cycle over a numerator of
// 62 + FRAC_BITS bits.
// After reset or a write to either rate register the state reloads in the steps
// PC_LOAD and PC_LOAD_ACC with in_stall high; a write to an unused index changes nothing.
// A finished result waits in the output register; the next report is taken
// meanwhile and the sequencer holds before its own result until out_stall drops.
// Top level of the sample rate estimator; depends on sre_pkg, sre_sequencer and
// sre_datapath.
module sample_rate_estimator_core #(
	parameter int FRAC_BITS = sre_pkg::FRAC_BITS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [sre_pkg::CNT_W-1:0]     sample_count,
	input  logic [sre_pkg::TS_W-1:0]      timestamp_us,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [sre_pkg::OUT_W-1:0]     rate_estimate,
	output logic [sre_pkg::OUT_W-1:0]     rate_deviation,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sre_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sre_pkg::RATE_W-1:0]    cfg_data
);

	sre_pkg::sre_ctrl_t   ctrl;
	sre_pkg::sre_status_t status;
	logic                 item_accept;
	logic                 cfg_we;
	logic                 cfg_reload;

	// register writes win over a report offered in the same cycle
	assign in_stall    = !ctrl.idle || cfg_valid;
	assign cfg_ready   = ctrl.idle;
	assign item_accept = in_valid && !in_stall;
	assign cfg_we      = cfg_valid && cfg_ready;
	// only the two rate registers restart the estimator
	assign cfg_reload  = cfg_we && (cfg_index == sre_pkg::REG_INITIAL_RATE
	                                || cfg_index == sre_pkg::REG_REFERENCE_RATE);

	sre_sequencer u_sequencer (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_accept (item_accept),
		.cfg_we      (cfg_reload),
		.status      (status),
		.ctrl        (ctrl)
	);

	sre_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.status         (status),
		.item_accept    (item_accept),
		.sample_count   (sample_count),
		.timestamp_us   (timestamp_us),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.rate_estimate  (rate_estimate),
		.rate_deviation (rate_deviation)
	);

endmodule

[rtl/core/sre_checker.sv]
// Port-level checks for the sample rate estimator core, bound to the top level.
// Depends on sre_pkg and sample_rate_estimator_core_defines.svh.
`include "sample_rate_estimator_core_defines.svh"

module sre_port_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [sre_pkg::OUT_W-1:0]     rate_estimate,
	input logic [sre_pkg::OUT_W-1:0]     rate_deviation,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [sre_pkg::CFG_IDX_W-1:0] cfg_index
);

	logic                          out_held;
	logic [2*sre_pkg::OUT_W-1:0]   result_pair;
	logic                          reload_write;

	assign out_held     = out_valid && out_stall;
	assign result_pair  = {rate_estimate, rate_deviation};
	assign reload_write = cfg_valid && cfg_ready
	                      && (cfg_index == sre_pkg::REG_INITIAL_RATE
	                          || cfg_index == sre_pkg::REG_REFERENCE_RATE);

	// a held result keeps its value
	`SRE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_held, out_valid && $stable(result_pair))

	// one report at a time: busy right after taking an item
	`SRE_ASSERT_NEXT(a_busy_after_item, clk, arst_n, in_valid && !in_stall, in_stall)

	// a rate register write starts a reload that blocks reports
	`SRE_ASSERT_NEXT(a_reload_blocks, clk, arst_n, reload_write, in_stall && !cfg_ready)

	// reports are only taken while the register port is open
	`SRE_ASSERT_SAME(a_idle_consistent, clk, arst_n, !in_stall, cfg_ready && !cfg_valid)

endmodule

bind sample_rate_estimator_core sre_port_checker u_sre_checker (.*);

[sim/sre_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the sample rate estimator core: watches the report, result and register
// channels, tracks the estimator state itself and compares every result. Needs sre_pkg.
module sre_checker
	import sre_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [CNT_W-1:0]     sample_count,
	input  logic [TS_W-1:0]      timestamp_us,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [OUT_W-1:0]     rate_estimate,
	input  logic [OUT_W-1:0]     rate_deviation,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [RATE_W-1:0]    cfg_data,
	output int                   mismatches,
	output int                   outstanding,
	output int                   results_checked
);

	localparam logic [63:0] SAMP_FULL  = (64'd1 << SAMP_W) - 64'd1;
	localparam logic [63:0] TIME_FULL  = (64'd1 << TIME_W) - 64'd1;
	localparam logic [63:0] RATE_CAP   = 64'd1 << 40;
	localparam logic [63:0] TIME_START = 64'd12000000 << 5;
	localparam logic [63:0] SHRINK_AT  = 64'd16000000 << 5;
	localparam logic [63:0] USEC       = 64'd1000000;

	typedef struct packed {
		logic [OUT_W-1:0] estimate;
		logic [OUT_W-1:0] deviation;
	} rate_pair_t;

	rate_pair_t expected_rates[$];

	logic [RATE_W-1:0] start_hz, nominal_hz;
	logic [63:0]       est_q, dev_q;
	logic [SAMP_W-1:0] samples_acc;
	logic [TIME_W-1:0] time_acc;
	logic [TS_W-1:0]   prev_ts;
	logic              seen_first;

	int mismatch_total = 0;
	int queued_n = 0;
	int results_total = 0;

	assign mismatches      = mismatch_total;
	assign outstanding     = queued_n;
	assign results_checked = results_total;

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_total++;
		if (mismatch_total <= 40)
			$display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
	endtask

	function automatic logic [63:0] clamp_to_nominal(input logic [63:0] v);
		logic [63:0] centre, band;
		centre = 64'(nominal_hz) << FRAC_BITS;
		band   = centre >> 6;
		if (v > centre + band)
			return centre + band;
		if (v < centre - band)
			return centre - band;
		return v;
	endfunction

	// Round half up: (s * 1e6 * 2^FRAC + t/2) / t, done as (2*s*1e6*2^FRAC + t) / 2t.
	function automatic logic [63:0] rounded_rate(input logic [SAMP_W-1:0] s,
			input logic [TIME_W-1:0] t);
		logic [127:0] num, quo;
		if (t == '0)
			return RATE_CAP;
		num = 128'(s) * 128'(USEC << (FRAC_BITS + 1)) + 128'(t);
		quo = num / (128'(t) << 1);
		if (quo >= 128'(RATE_CAP))
			return RATE_CAP;
		return quo[63:0];
	endfunction

	task automatic restart_tracking();
		logic [63:0] seed;
		seed        = 64'(start_hz) << FRAC_BITS;
		est_q       = clamp_to_nominal(seed);
		dev_q       = seed >> 12;
		samples_acc = SAMP_W'(((est_q >> FRAC_BITS) * 64'd12) << 5);
		time_acc    = TIME_W'(TIME_START);
		prev_ts     = '0;
		seen_first  = 1'b0;
	endtask

	task automatic take_report(input logic [CNT_W-1:0] cnt, input logic [TS_W-1:0] now);
		logic [TS_W-1:0] gap_us;
		logic [63:0]     s_sum, t_sum, inst, nxt, change;
		rate_pair_t      r;
		if (seen_first) begin
			gap_us      = now - prev_ts;
			s_sum       = 64'(samples_acc) + (64'(cnt) << 5);
			samples_acc = (s_sum > SAMP_FULL) ? SAMP_W'(SAMP_FULL) : SAMP_W'(s_sum);
			t_sum       = 64'(time_acc) + (64'(gap_us) << 5);
			time_acc    = (t_sum > TIME_FULL) ? TIME_W'(TIME_FULL) : TIME_W'(t_sum);
			inst        = rounded_rate(samples_acc, time_acc);
			nxt         = clamp_to_nominal((est_q * 64'd31 + inst + 64'd16) >> 5);
			change      = (nxt > est_q) ? nxt - est_q : est_q - nxt;
			dev_q       = (dev_q * 64'd15 + change + 64'd8) >> 4;
			est_q       = nxt;
			// shrink both windows once more than 16 s is accumulated
			if (64'(time_acc) > SHRINK_AT) begin
				samples_acc = SAMP_W'((64'(samples_acc) * 64'd3 + 64'd2) >> 2);
				time_acc    = TIME_W'((64'(time_acc) * 64'd3 + 64'd2) >> 2);
			end
		end
		prev_ts    = now;
		seen_first = 1'b1;
		r.estimate  = est_q[OUT_W-1:0];
		r.deviation = dev_q[OUT_W-1:0];
		expected_rates.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rate_pair_t want;
		if (!arst_n) begin
			start_hz   = RATE_RESET;
			nominal_hz = RATE_RESET;
			restart_tracking();
			expected_rates.delete();
		end else begin
			if (out_valid && !out_stall) begin
				results_total++;
				if (expected_rates.size() == 0) begin
					flag_mismatch("unexpected result, estimate", 64'(rate_estimate), 64'd0);
				end else begin
					want = expected_rates.pop_front();
					if (rate_estimate !== want.estimate)
						flag_mismatch("rate_estimate", 64'(rate_estimate), 64'(want.estimate));
					if (rate_deviation !== want.deviation)
						flag_mismatch("rate_deviation", 64'(rate_deviation),
							64'(want.deviation));
				end
			end
			if (cfg_valid && cfg_ready) begin
				// other indexes leave the state alone
				if (cfg_index == REG_INITIAL_RATE) begin
					start_hz = cfg_data;
					restart_tracking();
				end else if (cfg_index == REG_REFERENCE_RATE) begin
					nominal_hz = cfg_data;
					restart_tracking();
				end
			end
			if (in_valid && !in_stall)
				take_report(sample_count, timestamp_us);
		end
		queued_n <= expected_rates.size();
	end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// Top of the sample rate estimator testbench: clock, reset, report stimulus, register
// writes and the verdict. Needs sre_pkg, sample_rate_estimator_core and sre_checker.
module tb_top;
	import sre_pkg::*;

	localparam int FRAC_BITS     = FRAC_BITS_DEFAULT;
	localparam int IDLE_PCT      = 19;
	localparam int RANDOM_ITEMS  = 1100;
	localparam int QUIET_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 100;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);
	localparam logic [RATE_W-1:0]    RATE_TOP    = '1;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [CNT_W-1:0]     sample_count;
	logic [TS_W-1:0]      timestamp_us;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [OUT_W-1:0]     rate_estimate;
	logic [OUT_W-1:0]     rate_deviation;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [RATE_W-1:0]    cfg_data;

	int mismatches, outstanding, results_checked;
	int idle_pct = IDLE_PCT;
	int stall_hold = 0;
	int quiet_cycles = 0;
	int items_sent = 0;
	int writes_done = 0;
	int settings_tried = 1;
	logic [TS_W-1:0] clock_us = '0;

	sample_rate_estimator_core #(
		.FRAC_BITS(FRAC_BITS)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample_count   (sample_count),
		.timestamp_us   (timestamp_us),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.rate_estimate  (rate_estimate),
		.rate_deviation (rate_deviation),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	sre_checker #(
		.FRAC_BITS(FRAC_BITS)
	) i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.sample_count    (sample_count),
		.timestamp_us    (timestamp_us),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.rate_estimate   (rate_estimate),
		.rate_deviation  (rate_deviation),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.results_checked (results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Result side: random stalls plus an occasional long hold so finished results back up.
	always @(posedge clk) begin
		if (stall_hold != 0) begin
			out_stall  <= 1'b1;
			stall_hold <= stall_hold - 1;
		end else if (idle_pct != 0 && $urandom_range(1999) == 0) begin
			out_stall  <= 1'b1;
			stall_hold <= $urandom_range(120, 20);
		end else begin
			out_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("No handshake for %0d cycles, %0d results still owed", QUIET_LIMIT,
				outstanding);
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_report(input logic [CNT_W-1:0] cnt, input logic [TS_W-1:0] ts);
		if (idle_pct != 0 && $urandom_range(99) < 3) begin
			repeat ($urandom_range(90, 10)) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		sample_count <= cnt;
		timestamp_us <= ts;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		writes_done++;
	endtask

	task automatic reconfigure(input bit set_start, input bit set_nominal, input bit poke_spare,
			input logic [RATE_W-1:0] start, input logic [RATE_W-1:0] nominal);
		wait_drained();
		if (poke_spare) begin
			write_reg(REG_SPARE_A, RATE_W'($urandom));
			write_reg(REG_SPARE_B, RATE_W'($urandom));
		end
		if (set_start)
			write_reg(REG_INITIAL_RATE, start);
		if (set_nominal)
			write_reg(REG_REFERENCE_RATE, nominal);
		cfg_valid <= 1'b0;
		settings_tried++;
	endtask

	function automatic logic [RATE_W-1:0] pick_rate();
		case ($urandom_range(9))
			0: return RATE_W'(8000);
			1: return RATE_W'(11025);
			2: return RATE_W'(22050);
			3: return RATE_W'(32000);
			4: return RATE_W'(44100);
			5: return RATE_W'(48000);
			6: return RATE_W'(96000);
			7: return RATE_W'(192000);
			default: return RATE_W'($urandom_range(1, 1048575));
		endcase
	endfunction

	// Move a rate by up to +/- spread per mille, kept inside the register range.
	function automatic logic [RATE_W-1:0] nudge(input logic [RATE_W-1:0] hz, input int spread);
		longint v;
		v = longint'(hz) * (1000 + longint'($urandom_range(2 * spread)) - spread) / 1000;
		if (v < 1)
			v = 1;
		if (v > 1048575)
			v = 1048575;
		return RATE_W'(v);
	endfunction

	// Mostly steady buffer reports at a rate near nominal, with noise and broken reports.
	task automatic play_stream(input int n, input logic [RATE_W-1:0] nominal);
		logic [RATE_W-1:0] true_hz;
		logic [CNT_W-1:0]  cnt;
		longint unsigned   span, wobble;
		int                roll;
		true_hz = nudge(nominal, 40);
		if ($urandom_range(9) < 3)
			clock_us = $urandom;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(19) == 0)
				true_hz = nudge(nominal, 40);
			roll = $urandom_range(99);
			if (roll < 82) begin
				cnt = ($urandom_range(19) == 0) ? CNT_W'($urandom)
					: CNT_W'($urandom_range(2048, 64));
				span   = (longint'(cnt) * 64'd1000000) / longint'(true_hz);
				wobble = span / 16;
				if (wobble > 64'hFFFF_FFFF)
					wobble = 64'hFFFF_FFFF;
				span = span - wobble / 2 + $urandom_range(32'(wobble));
				clock_us = clock_us + TS_W'(span);
			end else if (roll < 92) begin
				cnt      = CNT_W'($urandom);
				clock_us = $urandom;
			end else if (roll < 96) begin
				// repeated timestamp
				cnt = CNT_W'($urandom);
			end else begin
				// step back in time, so the difference wraps
				cnt      = CNT_W'($urandom_range(600));
				clock_us = clock_us - TS_W'($urandom_range(100000, 1));
			end
			send_report(cnt, clock_us);
		end
	endtask

	initial begin
		int random_items;
		int phase;
		int n;
		int roll;
		logic [RATE_W-1:0] nominal, start;

		arst_n       = 1'b0;
		in_valid     = 1'b0;
		sample_count = '0;
		timestamp_us = '0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// First report at time zero only records it; then zero gaps, huge rates and wraps.
		send_report(CNT_W'(480), TS_W'(0));
		send_report(CNT_W'(480), TS_W'(10000));
		send_report(CNT_W'(0), TS_W'(10000));
		send_report('1, TS_W'(10001));
		send_report('1, TS_W'(10001));
		send_report(CNT_W'(0), TS_W'(32'hFFFF_FFF0));
		send_report(CNT_W'(480), TS_W'(32'h0000_0010));
		send_report(CNT_W'(1), '1);
		send_report(CNT_W'(4096), '1);
		send_report(CNT_W'(480), TS_W'(9999));

		// Clamp edges: estimate pulled up from the bottom, then down to a 1 Hz centre.
		reconfigure(1'b1, 1'b1, 1'b0, RATE_W'(1), RATE_TOP);
		send_report('0, '0);
		send_report('1, TS_W'(1));
		send_report('1, TS_W'(2));
		send_report(CNT_W'(512), TS_W'(10000));
		reconfigure(1'b1, 1'b1, 1'b0, RATE_TOP, RATE_W'(1));
		send_report(CNT_W'(1), TS_W'(5));
		send_report('1, TS_W'(6));
		send_report('0, '1);
		send_report(CNT_W'(100), TS_W'(100));

		// Writes to unused indexes must not restart the tracking.
		reconfigure(1'b0, 1'b0, 1'b1, '0, '0);
		send_report(CNT_W'(30), TS_W'(12000));
		send_report(CNT_W'(480), TS_W'(22000));

		random_items = 0;
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			n = $urandom_range(150, 50);
			if (n > RANDOM_ITEMS - random_items)
				n = RANDOM_ITEMS - random_items;
			idle_pct = (phase == 3) ? 0 : IDLE_PCT;
			nominal  = pick_rate();
			start    = ($urandom_range(3) == 0) ? RATE_W'($urandom_range(1, 1048575))
				: nudge(nominal, 30);
			roll = $urandom_range(99);
			reconfigure(roll < 85, roll < 70 || roll >= 85, $urandom_range(4) == 0, start,
				nominal);
			play_stream(n, nominal);
			random_items += n;
			phase++;
		end
		idle_pct = IDLE_PCT;

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d reports, compared %0d results, %0d register writes, %0d settings.",
			items_sent, results_checked, writes_done, settings_tried);
		$display("Streams mixed steady timing with repeated, wrapped and random timestamps.");
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
